// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define DQKS_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque check failed");

// Consequent holds in the same cycle as the antecedent.
`define DQKS_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Consequent holds in the cycle after the antecedent.
`define DQKS_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ----- rtl/dqks_pkg.sv -----
// Package for the deque with key search: sizes, op and status codes, types.
// No dependencies.
`timescale 1ns / 1ps

package dqks_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_BITS  = 16;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 3;
    localparam int KEY_W     = 16;
    localparam int STS_W     = 2;
    localparam int OUT_CNT_W = 7;
    localparam int SKEY_W    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SKEY_W-1:0] t_skey;

endpackage

// ----- rtl/dqks_if.sv -----
// Handshake interfaces for the deque: request word in, result word out.
// Depends on dqks_pkg.
`timescale 1ns / 1ps

interface dqks_in_if;
    logic                          valid;
    logic                          ready;
    logic [dqks_pkg::OP_W-1:0]     op;
    logic [dqks_pkg::KEY_W-1:0]    key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface dqks_res_if;
    logic                            valid;
    logic                            ready;
    logic [dqks_pkg::STS_W-1:0]      status;
    logic                            found;
    logic [dqks_pkg::OUT_CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output found, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    output ready);
endinterface

// ----- rtl/dqks_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dqks_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16,
    parameter int WORDS  = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/deque_with_key_search.sv -----
// Top level of the deque with key search: ring pointers, scan sequencer, result register.
// Depends on dqks_pkg, dqks_if, dqks_ram and assert_macros.svh.
//
//   channel   port    direction   word
//   request   i_in    in          op, key
//   result    o_res   out         status, found, entry_count
//
// For push, pop and unused ops the result is registered at the accept edge.
// Search steps through the held entries from the front, one key store read a cycle, stopping at a hit.
// Search on an empty deque is answered at the accept edge, not found.
// Reset empties the deque; the key store is not cleared.
// A waiting result holds off the next request unless it is taken in the same cycle;
// one request is in work at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deque_with_key_search (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqks_in_if.sink    i_in,
    dqks_res_if.source o_res
);

    localparam int SUM_W = dqks_pkg::CNT_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                          r_state, n_state;
    dqks_pkg::t_idx                r_front, n_front;
    dqks_pkg::t_cnt                r_count, n_count;
    dqks_pkg::t_idx                r_ptr, n_ptr;
    dqks_pkg::t_cnt                r_issued, n_issued;
    dqks_pkg::t_skey               r_key, n_key;
    logic                          r_out_valid, n_out_valid;
    logic [dqks_pkg::STS_W-1:0]    r_status, n_status;
    logic                          r_found, n_found;
    dqks_pkg::t_cnt                r_out_cnt, n_out_cnt;

    logic                          w_slot_free;
    logic                          w_acc;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_hit;
    logic                          w_last;
    logic                          w_in_scan;
    dqks_pkg::t_idx                w_front_dec;
    dqks_pkg::t_idx                w_front_inc;
    dqks_pkg::t_idx                w_ptr_inc;
    dqks_pkg::t_idx                w_back_pos;
    logic [SUM_W-1:0]              w_back_sum;

    logic                          w_we;
    dqks_pkg::t_idx                w_waddr;
    dqks_pkg::t_idx                w_raddr;
    dqks_pkg::t_skey               w_rdata;

    function automatic dqks_pkg::t_idx ring_inc(input dqks_pkg::t_idx idx);
        dqks_pkg::t_idx res;
        if (idx == dqks_pkg::IDX_W'(dqks_pkg::DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    dqks_ram #(
        .ADDR_W (dqks_pkg::IDX_W),
        .DATA_W (dqks_pkg::SKEY_W),
        .WORDS  (dqks_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.key[dqks_pkg::SKEY_W-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_in_scan   = (r_state == S_SCAN);

    assign w_full  = (r_count == dqks_pkg::CNT_W'(dqks_pkg::DEPTH));
    assign w_empty = (r_count == '0);

    assign w_front_dec = (r_front == '0) ? dqks_pkg::IDX_W'(dqks_pkg::DEPTH - 1)
                                         : r_front - 1'b1;
    assign w_front_inc = ring_inc(r_front);
    assign w_ptr_inc   = ring_inc(r_ptr);

    // back slot: front + count, wrapped once
    assign w_back_sum = SUM_W'(r_front) + SUM_W'(r_count);
    assign w_back_pos = (w_back_sum >= SUM_W'(dqks_pkg::DEPTH))
                      ? dqks_pkg::IDX_W'(w_back_sum - SUM_W'(dqks_pkg::DEPTH))
                      : dqks_pkg::IDX_W'(w_back_sum);

    // store is written only in idle, a search reads it only after a later accept
    assign w_raddr = (r_state == S_SCAN) ? r_ptr : r_front;
    assign w_hit   = (w_rdata == r_key);
    assign w_last  = (r_issued == r_count);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_issued    = r_issued;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_found     = r_found;
        n_out_cnt   = r_out_cnt;
        w_we        = 1'b0;
        w_waddr     = w_back_pos;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out_valid = 1'b1;
                    n_status    = dqks_pkg::ST_DONE;
                    n_found     = 1'b0;
                    case (i_in.op)
                        dqks_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = dqks_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        dqks_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = dqks_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_back_pos;
                                n_count = r_count + 1'b1;
                            end
                        end
                        dqks_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = dqks_pkg::ST_EMPTY;
                            end else begin
                                n_front = w_front_inc;
                                n_count = r_count - 1'b1;
                            end
                        end
                        dqks_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                n_status = dqks_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        dqks_pkg::OP_SEARCH: begin
                            if (!w_empty) begin
                                // front read issued this cycle; hold the result
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_ptr       = w_front_inc;
                                n_issued    = dqks_pkg::CNT_W'(1);
                                n_key       = i_in.key[dqks_pkg::SKEY_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_cnt = n_count;
                end
            end
            S_SCAN: begin
                if (w_hit || w_last) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = dqks_pkg::ST_DONE;
                    n_found     = w_hit;
                    n_out_cnt   = r_count;
                end else begin
                    n_ptr    = w_ptr_inc;
                    n_issued = r_issued + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_issued  <= n_issued;
        r_key     <= n_key;
        r_status  <= n_status;
        r_found   <= n_found;
        r_out_cnt <= n_out_cnt;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.found       = r_found;
    assign o_res.entry_count = dqks_pkg::OUT_CNT_W'(r_out_cnt);

    `DQKS_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= dqks_pkg::CNT_W'(dqks_pkg::DEPTH))
    `DQKS_IMPLY(a_scan_range, i_clk, i_rst_n, w_in_scan, (r_issued != '0) && (r_issued <= r_count))
    `DQKS_NEXT(a_scan_frozen, i_clk, i_rst_n, w_in_scan, $stable(r_count) && $stable(r_front))
    `DQKS_IMPLY(a_found_done, i_clk, i_rst_n, r_out_valid && r_found, r_status == dqks_pkg::ST_DONE)

endmodule

// ----- verif/tb_deque_with_key_search.sv -----
// Testbench for deque_with_key_search: pushes, pops and key searches with
// idle and stall phases, checked word by word against a ring predictor.
// Depends on dqks_pkg, dqks_if and the deque RTL.
`timescale 1ns / 1ps

module tb_deque_with_key_search;
    import dqks_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RANDOM_WORDS = 800;
    localparam int PACE_SPAN    = 100;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
    localparam int RECENT_MAX   = 16;
    localparam int REPORT_MAX   = 10;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_e;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        pace_e            pace;
        logic             hold;
    } word_t;

    typedef struct {
        logic [STS_W-1:0]     status;
        logic                 found;
        logic [OUT_CNT_W-1:0] count;
    } reply_t;

    logic i_clk;
    logic i_rst_n;

    dqks_in_if  req_if ();
    dqks_res_if res_if ();

    deque_with_key_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_res   (res_if)
    );

    word_t            pending_words[$];
    reply_t           expected_replies[$];
    logic [KEY_W-1:0] recent_keys[$];

    t_skey ring_keys[DEPTH];
    int    ring_front;
    int    ring_held;

    pace_e drive_pace;
    logic  req_taken;
    int    quiet_cycles;
    int    mismatches;

    pace_e gen_pace;
    logic  gen_hold;
    int    planned_held;

    function automatic reply_t deque_step(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        reply_t r;
        t_skey  k;
        r.status = ST_DONE;
        r.found  = 1'b0;
        k        = key[SKEY_W-1:0];
        case (op)
            OP_PUSH_FRONT: begin
                if (ring_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_front = (ring_front + DEPTH - 1) % DEPTH;
                    ring_keys[ring_front] = k;
                    ring_held++;
                end
            end
            OP_PUSH_BACK: begin
                if (ring_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_keys[(ring_front + ring_held) % DEPTH] = k;
                    ring_held++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_front = (ring_front + 1) % DEPTH;
                    ring_held--;
                end
            end
            OP_POP_BACK: begin
                if (ring_held == 0) r.status = ST_EMPTY;
                else ring_held--;
            end
            OP_SEARCH: begin
                for (int i = 0; i < ring_held; i++) begin
                    if (ring_keys[(ring_front + i) % DEPTH] == k) r.found = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = OUT_CNT_W'(ring_held);
        return r;
    endfunction

    task automatic note_mismatch(string what, reply_t want, reply_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t %s: expected status %0d found %0d count %0d, got status %0d found %0d count %0d",
                     $time, what, want.status, want.found, want.count,
                     got.status, got.found, got.count);
        end
    endtask

    task automatic plan_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        word_t w;
        w.op   = op;
        w.key  = key;
        w.pace = gen_pace;
        w.hold = gen_hold;
        pending_words.push_back(w);
        gen_hold = 1'b0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (planned_held < DEPTH) begin
                planned_held++;
                recent_keys.push_back(key);
                if (recent_keys.size() > RECENT_MAX) void'(recent_keys.pop_front());
            end
        end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (planned_held > 0) planned_held--;
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 4 && recent_keys.size() != 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (r < 6) return KEY_W'($urandom_range(7));
        return KEY_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_push();
        return ($urandom_range(1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [OP_W-1:0] pick_pop();
        return ($urandom_range(1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    function automatic logic [OP_W-1:0] pick_spare();
        case ($urandom_range(2))
            0:       return OP_SPARE_A;
            1:       return OP_SPARE_B;
            default: return OP_SPARE_C;
        endcase
    endfunction

    function automatic int pace_pct(pace_e p, logic sender);
        case (p)
            PACE_SEND_IDLE:  return sender ? 85 : 0;
            PACE_RECV_STALL: return sender ? 0 : 85;
            PACE_BOTH:       return 24;
            default:         return 0;
        endcase
    endfunction

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.op    = OP_PUSH_FRONT;
        req_if.key   = '0;
        res_if.ready = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // drive request words and result ready
    always @(negedge i_clk) begin
        word_t nxt;
        logic  load;
        load = 1'b0;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_taken) begin
                if (pending_words.size() != 0) begin
                    nxt  = pending_words[0];
                    load = !(nxt.hold && expected_replies.size() != 0) &&
                           ($urandom_range(99) >= pace_pct(nxt.pace, 1'b1));
                end
                req_if.valid <= load;
                if (load) begin
                    req_if.op  <= nxt.op;
                    req_if.key <= nxt.key;
                    drive_pace <= nxt.pace;
                    void'(pending_words.pop_front());
                end
            end
            res_if.ready <= ($urandom_range(99) >= pace_pct(drive_pace, 1'b0));
        end
    end

    // check results, predict accepted words, watch for a hang
    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        logic   any_taken;
        if (!i_rst_n) begin
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            any_taken = (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready);
            req_taken <= req_if.valid && req_if.ready;
            if (res_if.valid && res_if.ready) begin
                got.status = res_if.status;
                got.found  = res_if.found;
                got.count  = res_if.entry_count;
                if (expected_replies.size() == 0) begin
                    note_mismatch("unexpected result", got, got);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.count !== want.count)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (req_if.valid && req_if.ready)
                expected_replies.push_back(deque_step(req_if.op, req_if.key));
            quiet_cycles <= any_taken ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL deque_with_key_search");
                $finish;
            end
        end
    end

    initial begin
        int    random_words;
        int    sel;
        int    n;
        int    r;
        pace_e next_pace;

        ring_front   = 0;
        ring_held    = 0;
        mismatches   = 0;
        drive_pace   = PACE_FREE;
        gen_pace     = PACE_FREE;
        gen_hold     = 1'b0;
        planned_held = 0;
        random_words = 0;
        foreach (ring_keys[i]) ring_keys[i] = '0;

        plan_word(OP_POP_FRONT, 16'hFFFF);
        plan_word(OP_POP_BACK, 16'h0000);
        plan_word(OP_SEARCH, 16'h0000);
        plan_word(OP_SPARE_A, 16'h1234);
        plan_word(OP_SPARE_B, 16'hFFFF);
        plan_word(OP_SPARE_C, 16'h0000);
        plan_word(OP_PUSH_BACK, 16'h0000);
        plan_word(OP_PUSH_FRONT, 16'hFFFF);
        plan_word(OP_PUSH_BACK, 16'h1234);
        plan_word(OP_SEARCH, 16'hFFFF);
        plan_word(OP_SEARCH, 16'h1234);
        plan_word(OP_SEARCH, 16'h0000);
        plan_word(OP_SEARCH, 16'h5555);
        plan_word(OP_SPARE_C, 16'hFFFF);
        plan_word(OP_POP_FRONT, 16'h0000);
        plan_word(OP_SEARCH, 16'hFFFF);
        plan_word(OP_POP_BACK, 16'hFFFF);
        plan_word(OP_SEARCH, 16'h1234);
        plan_word(OP_POP_BACK, 16'h0000);
        plan_word(OP_POP_FRONT, 16'h0000);
        plan_word(OP_PUSH_FRONT, 16'hA5A5);
        plan_word(OP_SEARCH, 16'hA5A5);
        plan_word(OP_POP_FRONT, 16'h5A5A);

        gen_hold = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            next_pace = pace_e'((random_words / PACE_SPAN) % 4);
            if (next_pace != gen_pace) begin
                gen_pace = next_pace;
                gen_hold = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 5) begin
                n = DEPTH - planned_held + $urandom_range(3);
                repeat (n) plan_word(pick_push(), pick_key());
                random_words += n;
            end else if (sel < 10) begin
                n = planned_held + $urandom_range(3);
                repeat (n) plan_word(pick_pop(), KEY_W'($urandom));
                random_words += n;
            end else begin
                repeat (8) begin
                    r = $urandom_range(99);
                    if (r < 30) plan_word(pick_push(), pick_key());
                    else if (r < 55) plan_word(pick_pop(), KEY_W'($urandom));
                    else if (r < 95) plan_word(OP_SEARCH, pick_key());
                    else plan_word(pick_spare(), KEY_W'($urandom));
                    if (r < 95) random_words++;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every word is in and every result has come back
        while (pending_words.size() != 0 || req_if.valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_replies.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("PASS deque_with_key_search");
        end else begin
            $display("FAIL deque_with_key_search");
        end
        $finish;
    end

endmodule
